FILE: rtl/hfrs_pkg.sv
package hfrs_pkg;

	localparam int CosDepth = 1024;
	localparam int RomAw = $clog2(CosDepth + 1);
	localparam int FullTurn = 92160;

	localparam logic [2:0] CFG_COUNT = 3'd0;
	localparam logic [2:0] CFG_MEAN = 3'd1;
	localparam logic [2:0] CFG_AMP1 = 3'd2;
	localparam logic [2:0] CFG_PH1 = 3'd3;
	localparam logic [2:0] CFG_AMP2 = 3'd4;
	localparam logic [2:0] CFG_PH2 = 3'd5;
	localparam logic [2:0] CFG_AMP3 = 3'd6;
	localparam logic [2:0] CFG_PH3 = 3'd7;

	// One queued point between the front and the back.
	typedef struct packed {
		logic [11:0] idx1;
		logic [11:0] idx2;
		logic [11:0] idx3;
		logic signed [31:0] sample;
		logic last;
	} hfrs_item_t;

	// Quarter-wave cosine in Q1.30, built by a fixed-point Taylor series.
	function automatic logic [30:0] cos_rom(input logic [RomAw-1:0] r);
		logic [63:0] t, t2, term;
		logic signed [63:0] s;
		s = 64'sd1073741824;
		t = (64'(r) * 64'd1686629713 + 64'(CosDepth / 2)) / 64'(CosDepth);
		t2 = (t * t + (64'd1 << 29)) >> 30;
		term = 64'd1073741824;
		for (int n = 1; n <= 12; n++) begin
			term = ((term * t2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n % 2 == 1) s = s - $signed(term);
			else s = s + $signed(term);
		end
		if (s < 0) s = 0;
		if (s > 64'sd1073741824) s = 64'sd1073741824;
		return s[30:0];
	endfunction

endpackage

FILE: rtl/harmonic_fit_residual_sum_unit.sv
// Harmonic fit residual unit. Each accepted point passes the back end as a
// load step that also fetches the first cosine, one step per active harmonic
// on the shared multiplier, then saturation, residual square, accumulate and
// output, which waits out any output stall; the front end computes the angles
// ahead and a two-entry queue lets the next point wait there. The user must
// write configuration through a plain write port (index 0 harmonic count,
// 1 mean, then amplitude and phase per harmonic) only while the unit is idle;
// the unit does not enforce this. The sum of squares clears after a last point.
module harmonic_fit_residual_sum_unit import hfrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [16:0] phase_deg,
	input  logic [31:0] sample_value,
	input  logic last_point,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] fit_value,
	output logic [31:0] residual,
	output logic [62:0] sum_squares,
	output logic sum_final
);
	logic [1:0] count_q;
	logic signed [31:0] mean_q, a1_q, a2_q, a3_q;
	logic signed [16:0] p1_q, p2_q, p3_q;
	logic q_push, q_pop, q_full, q_empty;
	hfrs_item_t q_in, q_out;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0; mean_q <= '0; a1_q <= '0; a2_q <= '0; a3_q <= '0;
			p1_q <= '0; p2_q <= '0; p3_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COUNT: count_q <= cfg_data[1:0];
				CFG_MEAN: mean_q <= cfg_data;
				CFG_AMP1: a1_q <= cfg_data;
				CFG_PH1: p1_q <= cfg_data[16:0];
				CFG_AMP2: a2_q <= cfg_data;
				CFG_PH2: p2_q <= cfg_data[16:0];
				CFG_AMP3: a3_q <= cfg_data;
				CFG_PH3: p3_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	hfrs_front u_front (.clk, .arst_n, .in_valid, .phase_deg, .sample_value, .last_point,
		.ph1(p1_q), .ph2(p2_q), .ph3(p3_q), .q_full, .in_stall, .q_push, .q_item(q_in));

	hfrs_queue u_queue (.clk, .arst_n, .push(q_push), .din(q_in), .pop(q_pop),
		.full(q_full), .empty(q_empty), .dout(q_out));

	hfrs_back u_back (.clk, .arst_n, .q_empty, .q_item(q_out), .q_pop, .count(count_q),
		.mean(mean_q), .amp1(a1_q), .amp2(a2_q), .amp3(a3_q), .out_valid, .out_stall,
		.fit_value, .residual, .sum_squares, .sum_final);
endmodule

FILE: rtl/hfrs_front.sv
// Front: forms the three harmonic angles and reduces them to circle indexes.
module hfrs_front import hfrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [16:0] phase_deg,
	input  logic [31:0] sample_value,
	input  logic last_point,
	input  logic signed [16:0] ph1,
	input  logic signed [16:0] ph2,
	input  logic signed [16:0] ph3,
	input  logic q_full,
	output logic in_stall,
	output logic q_push,
	output hfrs_item_t q_item
);
	logic v_s1;
	logic signed [19:0] a1_s1, a2_s1, a3_s1;
	logic [31:0] y_s1;
	logic l_s1;

	// Circle index of an angle: reduce modulo a turn, then round to 4*D steps.
	// The angle is lifted by three turns and brought into one turn by three
	// compare and subtract steps. The rounding divide by a quarter step
	// (22.5 units) becomes (2*m + 22) / 45, done as a reciprocal multiply
	// that is exact for every value below 2^18.
	function automatic logic [11:0] circ_idx(input logic signed [19:0] a);
		logic [19:0] m;
		logic [17:0] v;
		logic [36:0] p;
		m = 20'(a + 20'sd276480);
		if (m >= 20'(4 * FullTurn)) m = m - 20'(4 * FullTurn);
		if (m >= 20'(2 * FullTurn)) m = m - 20'(2 * FullTurn);
		if (m >= 20'(FullTurn)) m = m - 20'(FullTurn);
		v = {m[16:0], 1'b0} + 18'd22;
		p = 37'(v) * 37'd372828;
		return p[35:24];
	endfunction

	assign in_stall = v_s1 && q_full;
	assign q_push = v_s1 && !q_full;
	assign q_item.idx1 = circ_idx(a1_s1);
	assign q_item.idx2 = circ_idx(a2_s1);
	assign q_item.idx3 = circ_idx(a3_s1);
	assign q_item.sample = $signed(y_s1);
	assign q_item.last = l_s1;

	// Angle register; the reduction follows on the queue side.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			a1_s1 <= 20'($signed(phase_deg)) + 20'(ph1);
			a2_s1 <= 20'($signed(phase_deg)) * 20'sd2 + 20'(ph2);
			a3_s1 <= 20'($signed(phase_deg)) * 20'sd3 + 20'(ph3);
			y_s1 <= sample_value;
			l_s1 <= last_point;
		end
	end
endmodule

FILE: rtl/hfrs_queue.sv
// Two-entry queue between front and back.
module hfrs_queue import hfrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  hfrs_item_t din,
	input  logic pop,
	output logic full,
	output logic empty,
	output hfrs_item_t dout
);
	hfrs_item_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= !wp_q;
			if (pop) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end
endmodule

FILE: rtl/hfrs_back.sv
// Back: the harmonic products share one multiplier; another squares the residual.
module hfrs_back import hfrs_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_empty,
	input  hfrs_item_t q_item,
	output logic q_pop,
	input  logic [1:0] count,
	input  logic signed [31:0] mean,
	input  logic signed [31:0] amp1,
	input  logic signed [31:0] amp2,
	input  logic signed [31:0] amp3,
	output logic out_valid,
	input  logic out_stall,
	output logic [31:0] fit_value,
	output logic [31:0] residual,
	output logic [62:0] sum_squares,
	output logic sum_final
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_H = 3'd1;
	localparam logic [2:0] ST_FIT = 3'd2;
	localparam logic [2:0] ST_SQ = 3'd3;
	localparam logic [2:0] ST_ACC = 3'd4;
	localparam logic [2:0] ST_OUT = 3'd5;

	logic [2:0] st_q;
	logic [1:0] k_q;
	hfrs_item_t it_q;
	logic signed [35:0] fit_q;
	logic signed [31:0] res_q;
	logic [62:0] acc_q;
	logic [63:0] sq_q;
	logic [1:0] nk;
	logic [11:0] idx;
	logic [1:0] quad;
	logic [9:0] rr;
	logic [RomAw-1:0] raddr;
	logic [30:0] cos_mem [CosDepth + 1];
	logic [30:0] cmag_q;
	logic neg_q;
	logic signed [31:0] cval;
	logic signed [31:0] amp;
	logic signed [63:0] prod;
	logic signed [33:0] term;
	logic signed [31:0] fsat;
	logic signed [32:0] rdiff;
	logic signed [31:0] rsat;
	logic [31:0] mag;
	logic [63:0] room;

	// Quarter-wave cosine table, filled once from the package series.
	initial begin
		for (int r = 0; r <= CosDepth; r++) cos_mem[r] = cos_rom(RomAw'(r));
	end

	always_comb begin
		// The table read is registered ahead of its use: the load cycle fetches the
		// first harmonic, each harmonic cycle fetches the next one.
		nk = (st_q == ST_H) ? k_q + 2'd1 : 2'd0;
		case (nk)
			2'd0: idx = q_item.idx1;
			2'd1: idx = it_q.idx2;
			default: idx = it_q.idx3;
		endcase
		case (k_q)
			2'd0: amp = amp1;
			2'd1: amp = amp2;
			default: amp = amp3;
		endcase
		quad = idx[11:10];
		rr = idx[9:0];
		raddr = (quad[0]) ? RomAw'(CosDepth) - RomAw'(rr) : RomAw'(rr);
		cval = neg_q ? -$signed({1'b0, cmag_q}) : $signed({1'b0, cmag_q});
		prod = 64'(amp) * 64'(cval);
		term = 34'((prod + 64'sd536870912) >>> 30);
		fsat = (fit_q > 36'sd2147483647) ? 32'sh7FFFFFFF :
			(fit_q < -36'sd2147483648) ? 32'sh80000000 : fit_q[31:0];
		rdiff = 33'($signed(it_q.sample)) - 33'(fsat);
		rsat = (rdiff > 33'sd2147483647) ? 32'sh7FFFFFFF :
			(rdiff < -33'sd2147483648) ? 32'sh80000000 : rdiff[31:0];
		mag = res_q[31] ? 32'(-33'(res_q)) : 32'(res_q);
		room = 64'h7FFFFFFFFFFFFFFF - 64'(acc_q);
	end

	// Registered table read and the sign of its quadrant.
	always_ff @(posedge clk) begin
		cmag_q <= cos_mem[raddr];
		neg_q <= (quad == 2'd1 || quad == 2'd2);
	end

	assign q_pop = st_q == ST_IDLE && !q_empty;
	assign out_valid = st_q == ST_OUT;
	assign fit_value = fsat;
	assign residual = res_q;
	assign sum_squares = sq_q[62:0];
	assign sum_final = it_q.last;

	// Sequencer: one harmonic per cycle, then saturate, square, add and output.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			k_q <= 2'd0;
			acc_q <= 63'd0;
		end else begin
			case (st_q)
				ST_IDLE: if (!q_empty) begin
					k_q <= 2'd0;
					st_q <= (count == 2'd0) ? ST_FIT : ST_H;
				end
				ST_H: begin
					k_q <= k_q + 2'd1;
					if (k_q + 2'd1 >= count) st_q <= ST_FIT;
				end
				ST_FIT: st_q <= ST_SQ;
				ST_SQ: st_q <= ST_ACC;
				ST_ACC: begin
					acc_q <= (sq_q > room) ? 63'h7FFFFFFFFFFFFFFF : acc_q + sq_q[62:0];
					st_q <= ST_OUT;
				end
				ST_OUT: if (!out_stall) begin
					if (it_q.last) acc_q <= 63'd0;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: if (!q_empty) begin
				it_q <= q_item;
				fit_q <= 36'(mean);
			end
			ST_H: fit_q <= fit_q + 36'(term);
			ST_FIT: res_q <= rsat;
			ST_SQ: sq_q <= 64'(mag) * 64'(mag);
			ST_ACC: sq_q <= (sq_q > room) ? 64'h7FFFFFFFFFFFFFFF : 64'(acc_q) + sq_q;
			default: ;
		endcase
	end
endmodule
